### hw/rtl/tak_pkg.sv
// shared types, constants and key lookup for the text autotype key matrix
package tak_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_TICK = 2'd1,
    ACT_KEY  = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic       mapped;
    logic       shift;
    logic [7:0] key;
  } key_code_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] text_char;
    logic [7:0] key_code;
    logic       key_down;
    logic       shift_held;
    logic [3:0] row_select;
  } item_t;

  typedef logic [15:0][7:0] matrix_t;

  localparam logic [7:0] SHIFT_KEY = 8'h25;
  localparam logic [7:0] CARET     = 8'h5e;

  localparam logic [7:0] LETTER_KEY [26] = '{
    8'h85, 8'h66, 8'h76, 8'h75, 8'h72, 8'h65, 8'h64, 8'h54, 8'h43, 8'h55, 8'h45, 8'h44, 8'h46,
    8'h56, 8'h42, 8'h33, 8'h83, 8'h62, 8'h74, 8'h63, 8'h52, 8'h67, 8'h73, 8'h77, 8'h53, 8'h87
  };

  localparam logic [7:0] DIGIT_KEY [10] = '{
    8'h40, 8'h80, 8'h81, 8'h71, 8'h70, 8'h61, 8'h60, 8'h51, 8'h50, 8'h41
  };

  function automatic key_code_t mk(logic shift, logic [7:0] key);
    key_code_t r;
    r.mapped = 1'b1;
    r.shift  = shift;
    r.key    = key;
    return r;
  endfunction

  // symbols and control codes, unmapped by default
  function automatic key_code_t sym_key(logic [7:0] c);
    key_code_t r;
    r = '0;
    case (c)
      8'd9:   r = mk(1'b0, 8'h84);
      8'd10:  r = mk(1'b0, 8'h06);
      8'd27:  r = mk(1'b0, 8'h82);
      8'd32:  r = mk(1'b0, 8'h57);
      8'd33:  r = mk(1'b1, 8'h80);
      8'd34:  r = mk(1'b1, 8'h81);
      8'd35:  r = mk(1'b1, 8'h71);
      8'd36:  r = mk(1'b1, 8'h70);
      8'd37:  r = mk(1'b1, 8'h61);
      8'd38:  r = mk(1'b1, 8'h60);
      8'd39:  r = mk(1'b1, 8'h51);
      8'd40:  r = mk(1'b1, 8'h50);
      8'd41:  r = mk(1'b1, 8'h41);
      8'd42:  r = mk(1'b1, 8'h35);
      8'd43:  r = mk(1'b1, 8'h34);
      8'd44:  r = mk(1'b0, 8'h47);
      8'd45:  r = mk(1'b0, 8'h31);
      8'd46:  r = mk(1'b0, 8'h07);
      8'd47:  r = mk(1'b0, 8'h36);
      8'd58:  r = mk(1'b0, 8'h35);
      8'd59:  r = mk(1'b0, 8'h34);
      8'd60:  r = mk(1'b1, 8'h47);
      8'd61:  r = mk(1'b1, 8'h31);
      8'd62:  r = mk(1'b1, 8'h37);
      8'd63:  r = mk(1'b1, 8'h36);
      8'd64:  r = mk(1'b0, 8'h32);
      8'd91:  r = mk(1'b0, 8'h21);
      8'd92:  r = mk(1'b0, 8'h26);
      8'd93:  r = mk(1'b0, 8'h23);
      8'd94:  r = mk(1'b0, 8'h30);
      8'd95:  r = mk(1'b1, 8'h40);
      8'd96:  r = mk(1'b1, 8'h26);
      8'd123: r = mk(1'b1, 8'h21);
      8'd124: r = mk(1'b1, 8'h32);
      8'd125: r = mk(1'b1, 8'h23);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic key_code_t key_for(logic [7:0] c, logic az);
    key_code_t  r;
    logic [7:0] cc;
    logic [7:0] li;
    logic [7:0] di;
    r  = '0;
    cc = c;
    li = c - 8'h61;
    di = c - 8'h30;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = mk(1'b0, LETTER_KEY[li[4:0]]);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = mk(az, DIGIT_KEY[di[3:0]]);
    end else if (az && c == 8'h4d) begin
      r = mk(1'b1, 8'h35);
    end else if (az && c == 8'h2a) begin
      r = mk(1'b1, 8'h46);
    end else if (az && c == 8'h22) begin
      r = mk(1'b0, 8'h71);
    end else if (az && c == 8'h23) begin
      r = mk(1'b1, 8'h81);
    end else begin
      if (az) begin
        case (c)
          8'h41:   cc = 8'h51;
          8'h51:   cc = 8'h41;
          8'h57:   cc = 8'h5a;
          8'h5a:   cc = 8'h57;
          default: cc = c;
        endcase
      end
      li = cc - 8'h41;
      if (cc >= 8'h41 && cc <= 8'h5a) begin
        r = mk(1'b1, LETTER_KEY[li[4:0]]);
      end else begin
        r = sym_key(cc);
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/tak_in_if.sv
// input item channel
interface tak_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] text_char;
  logic [7:0] key_code;
  logic       key_down;
  logic       shift_held;
  logic [3:0] row_select;

  modport source (output valid, action, text_char, key_code, key_down, shift_held, row_select,
                  input ready);
  modport sink (input valid, action, text_char, key_code, key_down, shift_held, row_select,
                output ready);
endinterface

### hw/rtl/tak_out_if.sv
// result item channel
interface tak_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_data;
  logic       tape_start;
  logic       typing_active;

  modport source (output valid, row_data, tape_start, typing_active, input ready);
  modport sink (input valid, row_data, tape_start, typing_active, output ready);
endinterface

### hw/rtl/tak_ctrl.sv
// controller state machine: accept, execute, output register handshake
module tak_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output tak_pkg::cmd_t cmd_o
);

  tak_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tak_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tak_pkg::ST_EXEC;
      end
      tak_pkg::ST_EXEC: begin
        if (out_free) state_d = tak_pkg::ST_IDLE;
      end
      default: state_d = tak_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      tak_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      tak_pkg::ST_EXEC: begin
        cmd_o.execute = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tak_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // every transfer in is followed by an execute cycle
  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == tak_pkg::ST_EXEC)
    else $error("capture not followed by execute");

  // a new result appears only from an execute cycle
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.execute))
    else $error("result valid without execute");

endmodule

### hw/rtl/tak_datapath.sv
// datapath: text store, pointers, held key, key matrix and result register
module tak_datapath #(
  parameter int unsigned TEXT_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tak_pkg::cmd_t cmd_i,
  input  logic          layout_we_i,
  input  logic          layout_wdata_i,
  input  logic [1:0]    action_i,
  input  logic [7:0]    text_char_i,
  input  logic [7:0]    key_code_i,
  input  logic          key_down_i,
  input  logic          shift_held_i,
  input  logic [3:0]    row_select_i,
  output logic [7:0]    row_data_o,
  output logic          tape_start_o,
  output logic          typing_active_o
);

  localparam int unsigned AW = $clog2(TEXT_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TEXT_DEPTH - 1);

  logic [7:0]       mem_q [TEXT_DEPTH];
  logic [7:0]       rdata_q;
  tak_pkg::item_t   item_q;
  logic [AW-1:0]    load_ptr_q, load_ptr_d;
  logic [AW-1:0]    type_ptr_q, type_ptr_d;
  logic [7:0]       held_q, held_d;
  logic             typing_q, typing_d;
  logic             layout_q;
  tak_pkg::matrix_t matrix_q, matrix_d;
  logic             mem_we;
  logic             tape;
  logic [7:0]       row_q;
  logic             tape_q;
  logic             active_q;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic tak_pkg::matrix_t set_key(tak_pkg::matrix_t m, logic [7:0] key,
                                               logic down);
    tak_pkg::matrix_t r;
    r = m;
    for (int i = 0; i < 16; i++) begin
      if (key[7:4] == 4'(i)) r[i][key[2:0]] = !down;
    end
    return r;
  endfunction

  function automatic tak_pkg::matrix_t apply_code(tak_pkg::matrix_t m,
                                                  tak_pkg::key_code_t code, logic down);
    tak_pkg::matrix_t r;
    r = m;
    if (code.mapped) begin
      if (code.shift) r = set_key(r, tak_pkg::SHIFT_KEY, down);
      r = set_key(r, code.key, down);
    end
    return r;
  endfunction

  // item capture and text store read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q.action     <= tak_pkg::action_e'(action_i);
      item_q.text_char  <= text_char_i;
      item_q.key_code   <= key_code_i;
      item_q.key_down   <= key_down_i;
      item_q.shift_held <= shift_held_i;
      item_q.row_select <= row_select_i;
      rdata_q           <= mem_q[type_ptr_q];
    end
    if (mem_we) mem_q[load_ptr_q] <= item_q.text_char;
  end

  always_comb begin
    load_ptr_d = load_ptr_q;
    type_ptr_d = type_ptr_q;
    held_d     = held_q;
    typing_d   = typing_q;
    matrix_d   = matrix_q;
    mem_we     = 1'b0;
    tape       = 1'b0;
    if (cmd_i.execute) begin
      unique case (item_q.action)
        tak_pkg::ACT_LOAD: begin
          mem_we     = 1'b1;
          load_ptr_d = ptr_inc(load_ptr_q);
          if (item_q.text_char == 8'h00) begin
            load_ptr_d = '0;
            type_ptr_d = '0;
            typing_d   = 1'b1;
          end
        end
        tak_pkg::ACT_TICK: begin
          if (typing_q) begin
            if (rdata_q == tak_pkg::CARET) begin
              type_ptr_d = ptr_inc(type_ptr_q);
              tape       = 1'b1;
            end else if (rdata_q != 8'h00 && held_q == 8'h00) begin
              matrix_d = apply_code(matrix_q, tak_pkg::key_for(rdata_q, layout_q), 1'b1);
              held_d   = rdata_q;
            end else if (rdata_q != 8'h00) begin
              matrix_d   = apply_code(matrix_q, tak_pkg::key_for(held_q, layout_q), 1'b0);
              held_d     = 8'h00;
              type_ptr_d = ptr_inc(type_ptr_q);
            end else begin
              typing_d = 1'b0;
              matrix_d = '1;
            end
          end
        end
        tak_pkg::ACT_KEY: begin
          if (item_q.shift_held) begin
            matrix_d = set_key(matrix_d, tak_pkg::SHIFT_KEY, item_q.key_down);
          end
          matrix_d = set_key(matrix_d, item_q.key_code, item_q.key_down);
        end
        tak_pkg::ACT_READ: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q <= '0;
      type_ptr_q <= '0;
      held_q     <= 8'h00;
      typing_q   <= 1'b0;
      matrix_q   <= '1;
      layout_q   <= 1'b0;
    end else begin
      load_ptr_q <= load_ptr_d;
      type_ptr_q <= type_ptr_d;
      held_q     <= held_d;
      typing_q   <= typing_d;
      matrix_q   <= matrix_d;
      if (layout_we_i) layout_q <= layout_wdata_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      row_q    <= matrix_d[item_q.row_select];
      tape_q   <= tape;
      active_q <= typing_d;
    end
  end

  assign row_data_o      = row_q;
  assign tape_start_o    = tape_q;
  assign typing_active_o = active_q;

  // end of text releases every key
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(typing_q) |-> matrix_q == '1)
    else $error("matrix not cleared at end of text");

  // a caret skip happens only while typing
  a_tape_typing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tape |-> (typing_q && typing_d))
    else $error("tape pulse outside typing");

  // pointers stay inside the store
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_ptr_q <= LAST) && (type_ptr_q <= LAST))
    else $error("pointer out of range");

endmodule

### hw/rtl/text_autotype_key_matrix.sv
// top level: text autotype into a 16x8 active-low key matrix
//
//   port            dir   kind        contents
//   in_i            in    valid/ready action, text_char, key_code, key_down, shift_held,
//                                     row_select
//   out_o           out   valid/ready row_data, tape_start, typing_active
//   layout_we_i     in    write       layout_mode register, data on layout_wdata_i
//
// for every item, the transfer cycle reads the text store at the type pointer;
// the execute cycle then updates the matrix and loads the result register.
// a new item is taken while the previous result waits in the result register;
// the execute cycle stalls while that register is full and not taken.
// reset clears pointers, held key, typing flag, layout and the matrix; the text
// store gets no clearing pass.
module text_autotype_key_matrix #(
  parameter int unsigned TEXT_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     layout_we_i,
  input  logic     layout_wdata_i,
  tak_in_if.sink   in_i,
  tak_out_if.source out_o
);

  tak_pkg::cmd_t cmd;

  tak_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  tak_datapath #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .layout_we_i     (layout_we_i),
    .layout_wdata_i  (layout_wdata_i),
    .action_i        (in_i.action),
    .text_char_i     (in_i.text_char),
    .key_code_i      (in_i.key_code),
    .key_down_i      (in_i.key_down),
    .shift_held_i    (in_i.shift_held),
    .row_select_i    (in_i.row_select),
    .row_data_o      (out_o.row_data),
    .tape_start_o    (out_o.tape_start),
    .typing_active_o (out_o.typing_active)
  );

endmodule
